// ===== design/nwc_pkg.sv =====
// Package for the normalized wake convolution: widths, command codes and sequencer states.
package nwc_pkg;

   localparam int BINS_DEFAULT = 256;

   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 9;
   localparam int SAMPLE_W = 16;
   localparam int CHARGE_W = 32;
   localparam int FORCE_W  = 32;
   localparam int BIN_W    = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_WAKE    = 2'd0,
      CMD_LOAD_DENSITY = 2'd1,
      CMD_COMPUTE      = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_DIV,
      S_FIN
   } state_type;

endpackage

// ===== design/nwc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module nwc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/normalized_wake_convolution.sv =====
// Top level of the normalized wake convolution: load, MAC walk, bit-serial division.
//
//  channel | direction | handshake              | payload
//  req_    | in        | req_valid / req_stall  | cmd, index, wake_value, density_value,
//          |           |                        | total_charge
//  rsp_    | out       | rsp_valid / rsp_stall  | force_res, bin, charge_zero, saturated
//
// A load item returns nothing. A compute item does one multiply-accumulate per table entry,
// then produces one quotient bit per cycle from a single 33-bit compare and subtract unit
// (at zero charge the division is skipped).
// Reset is synchronous and clears the sequencer and the result valid; the tables keep
// whatever they hold and must be loaded before use.
// req_stall is high while a compute item is in progress; a stalled result waits in the
// output register and holds the sequencer in its final state.
module normalized_wake_convolution #(
   parameter int BINS = nwc_pkg::BINS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [nwc_pkg::CMD_W-1:0]          req_cmd,
   input  logic [nwc_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [nwc_pkg::SAMPLE_W-1:0] req_wake_value,
   input  logic [nwc_pkg::SAMPLE_W-1:0]       req_density_value,
   input  logic [nwc_pkg::CHARGE_W-1:0]       req_total_charge,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nwc_pkg::FORCE_W-1:0] rsp_force_res,
   output logic [nwc_pkg::BIN_W-1:0]          rsp_bin,
   output logic                               rsp_charge_zero,
   output logic                               rsp_saturated
);

   localparam int DENS_AW = $clog2(BINS);
   localparam int WAKE_AW = $clog2(2 * BINS);
   localparam int IDX_W   = WAKE_AW + nwc_pkg::INDEX_W;
   localparam int PROD_W  = 2 * nwc_pkg::SAMPLE_W + 1;
   localparam int ACC_W   = PROD_W + DENS_AW;
   localparam int DIV_CW  = $clog2(ACC_W + 1);
   localparam int CW      = nwc_pkg::CHARGE_W;
   localparam logic [ACC_W-1:0] QMAX_POS = ACC_W'(64'h7fff_ffff);
   localparam logic [ACC_W-1:0] QMAX_NEG = ACC_W'(64'h8000_0000);

   nwc_pkg::state_type state_ff, state_in;

   logic                 req_accept;
   logic [IDX_W-1:0]     idx_wide;
   logic                 wake_in_range;
   logic                 dens_in_range;
   logic                 compute_start;
   logic                 wake_we;
   logic                 dens_we;
   logic                 rd_en;
   logic                 last_issue;
   logic                 pipe_empty;
   logic                 div_last;
   logic                 out_free;

   logic [DENS_AW-1:0]   cnt_ff, cnt_in;
   logic [WAKE_AW-1:0]   wake_addr_ff, wake_addr_in;
   logic [DIV_CW-1:0]    div_cnt_ff, div_cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 prod_vld_ff, prod_vld_in;

   logic [nwc_pkg::SAMPLE_W-1:0] dens_rd;
   logic [nwc_pkg::SAMPLE_W-1:0] wake_rd;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [CW-1:0]            charge_ff, charge_in;
   logic [nwc_pkg::BIN_W-1:0] bin_ff, bin_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic [ACC_W-1:0]         quo_ff, quo_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;

   logic [CW:0]              trial;
   logic [CW:0]              diff;
   logic                     fits;
   logic [ACC_W-1:0]         acc_mag;

   logic                     sat_now;
   logic [nwc_pkg::FORCE_W-1:0] force_now;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [nwc_pkg::FORCE_W-1:0] rsp_force_ff, rsp_force_in;
   logic [nwc_pkg::BIN_W-1:0] rsp_bin_ff, rsp_bin_in;
   logic                     rsp_zero_ff, rsp_zero_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   // ---------------------------------------------------------------- decode
   assign req_accept    = req_valid && !req_stall;
   assign idx_wide      = {{WAKE_AW{1'b0}}, req_index};
   assign wake_in_range = 32'(req_index) < 32'(2 * BINS);
   assign dens_in_range = 32'(req_index) < 32'(BINS);

   always_comb begin
      wake_we       = 1'b0;
      dens_we       = 1'b0;
      compute_start = 1'b0;
      unique case (nwc_pkg::cmd_type'(req_cmd))
         nwc_pkg::CMD_LOAD_WAKE:    wake_we       = req_accept && wake_in_range;
         nwc_pkg::CMD_LOAD_DENSITY: dens_we       = req_accept && dens_in_range;
         nwc_pkg::CMD_COMPUTE:      compute_start = req_accept && dens_in_range;
         default: ;
      endcase
   end

   assign last_issue = cnt_ff == DENS_AW'(BINS - 1);
   assign pipe_empty = !rd_vld_ff && !prod_vld_ff;
   assign div_last   = div_cnt_ff == DIV_CW'(ACC_W - 1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nwc_pkg::S_IDLE:  if (compute_start) state_in = nwc_pkg::S_MAC;
         nwc_pkg::S_MAC:   if (last_issue) state_in = nwc_pkg::S_DRAIN;
         nwc_pkg::S_DRAIN: begin
            if (pipe_empty) begin
               state_in = (charge_ff == '0) ? nwc_pkg::S_FIN : nwc_pkg::S_DIV;
            end
         end
         nwc_pkg::S_DIV:   if (div_last) state_in = nwc_pkg::S_FIN;
         nwc_pkg::S_FIN:   if (out_free) state_in = nwc_pkg::S_IDLE;
         default:          state_in = nwc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      unique case (state_ff)
         nwc_pkg::S_IDLE: req_stall = 1'b0;
         nwc_pkg::S_MAC:  rd_en     = 1'b1;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- tables
   nwc_ram #(
      .WIDTH (nwc_pkg::SAMPLE_W),
      .DEPTH (2 * BINS)
   ) u_wake_ram (
      .clock   (clock),
      .wr_en   (wake_we),
      .wr_addr (idx_wide[WAKE_AW-1:0]),
      .wr_data (req_wake_value),
      .rd_en   (rd_en),
      .rd_addr (wake_addr_ff),
      .rd_data (wake_rd)
   );

   nwc_ram #(
      .WIDTH (nwc_pkg::SAMPLE_W),
      .DEPTH (BINS)
   ) u_dens_ram (
      .clock   (clock),
      .wr_en   (dens_we),
      .wr_addr (idx_wide[DENS_AW-1:0]),
      .wr_data (req_density_value),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (dens_rd)
   );

   // ---------------------------------------------------------------- datapath
   // The wake address starts at BINS + i and steps down as the density index steps up.
   always_comb begin
      cnt_in       = cnt_ff;
      wake_addr_in = wake_addr_ff;
      div_cnt_in   = div_cnt_ff;
      charge_in    = charge_ff;
      bin_in       = bin_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;

      prod_in     = $signed({1'b0, dens_rd}) * $signed(wake_rd);
      rd_vld_in   = state_ff == nwc_pkg::S_MAC;
      prod_vld_in = rd_vld_ff;

      acc_mag = acc_ff[ACC_W-1] ? (~acc_ff + 1'b1) : acc_ff;

      trial = {rem_ff, quo_ff[ACC_W-1]};
      diff  = trial - {1'b0, charge_ff};
      fits  = trial >= {1'b0, charge_ff};

      if (compute_start) begin
         cnt_in       = '0;
         wake_addr_in = WAKE_AW'(BINS) + idx_wide[WAKE_AW-1:0];
         charge_in    = req_total_charge;
         bin_in       = req_index[nwc_pkg::BIN_W-1:0];
         acc_in       = '0;
      end else begin
         if (state_ff == nwc_pkg::S_MAC) begin
            cnt_in       = cnt_ff + 1'b1;
            wake_addr_in = wake_addr_ff - 1'b1;
         end
         if (prod_vld_ff) begin
            acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
      end

      if (state_ff == nwc_pkg::S_DRAIN && pipe_empty) begin
         quo_in     = acc_mag;
         rem_in     = '0;
         neg_in     = acc_ff[ACC_W-1];
         zero_in    = charge_ff == '0;
         div_cnt_in = '0;
      end else if (state_ff == nwc_pkg::S_DIV) begin
         // Restoring division: one quotient bit per cycle, shifted in from the right.
         rem_in     = fits ? diff[CW-1:0] : trial[CW-1:0];
         quo_in     = {quo_ff[ACC_W-2:0], fits};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      sat_now   = 1'b0;
      force_now = '0;
      if (!zero_ff) begin
         if (neg_ff) begin
            sat_now   = quo_ff > QMAX_NEG;
            force_now = sat_now ? 32'h8000_0000 : (~quo_ff[nwc_pkg::FORCE_W-1:0] + 1'b1);
         end else begin
            sat_now   = quo_ff > QMAX_POS;
            force_now = sat_now ? 32'h7fff_ffff : quo_ff[nwc_pkg::FORCE_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_force_in = rsp_force_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (state_ff == nwc_pkg::S_FIN && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_force_in = force_now;
         rsp_bin_in   = bin_ff;
         rsp_zero_in  = zero_ff;
         rsp_sat_in   = sat_now;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nwc_pkg::S_IDLE;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      wake_addr_ff <= wake_addr_in;
      div_cnt_ff   <= div_cnt_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      charge_ff    <= charge_in;
      bin_ff       <= bin_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      zero_ff      <= zero_in;
      rsp_force_ff <= rsp_force_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_zero_ff  <= rsp_zero_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_force_res   = rsp_force_ff;
   assign rsp_bin         = rsp_bin_ff;
   assign rsp_charge_zero = rsp_zero_ff;
   assign rsp_saturated   = rsp_sat_ff;

`ifndef SYNTHESIS
   a_div_rem_below_charge: assert property (@(posedge clock) disable iff (reset)
      state_ff == nwc_pkg::S_DIV |-> rem_ff < charge_ff)
      else $error("division remainder is not below the charge");

   a_div_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == nwc_pkg::S_DIV |-> !rd_vld_ff && !prod_vld_ff)
      else $error("division started while products were still in flight");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == nwc_pkg::S_FIN)
      else $error("result appeared without a finished computation");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_charge_zero && rsp_saturated))
      else $error("zero charge and saturation flagged together");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == nwc_pkg::S_MAC || state_ff == nwc_pkg::S_DIV |-> req_stall)
      else $error("input taken while a computation was in progress");
`endif

endmodule
